/* sv/ising_pkg.sv */
// shared types, sizes and codes for the ising metropolis site update block
// no dependencies; used by the top level and the testbench

package ising_pkg;

    // lattice geometry
    localparam int unsigned LATTICE_WIDTH  = 64;
    localparam int unsigned LATTICE_HEIGHT = 64;

    // width of the site coordinate fields on the input channel
    localparam int unsigned COORD_W = 6;

    localparam int unsigned X_W = $clog2(LATTICE_WIDTH);
    localparam int unsigned Y_W = $clog2(LATTICE_HEIGHT);

    localparam int unsigned PROB_W  = 32;
    localparam int unsigned EIDX_W  = 3;
    localparam int unsigned CFG_IDX_W = 1;

    typedef logic [X_W-1:0]           col_t;
    typedef logic [Y_W-1:0]           line_t;
    typedef logic [LATTICE_WIDTH-1:0] row_t;
    typedef logic [COORD_W-1:0]       coord_t;
    typedef logic [PROB_W-1:0]        prob_t;
    typedef logic [EIDX_W-1:0]        eidx_t;

    // input item modes; code 3 is unused and acts as a read
    typedef enum logic [1:0] {
        MODE_STEP  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROB_PLUS4 = 1'b0,
        CFG_PROB_PLUS8 = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_EXEC
    } state_t;

    // coordinate modulo n by restoring shift-subtract, one step per input bit
    function automatic int unsigned wrap_coord(input coord_t v, input int unsigned n);
        int unsigned r;
        r = int'(v);
        for (int k = COORD_W - 1; k >= 0; k--) begin
            if (r >= (n << k)) begin
                r = r - (n << k);
            end
        end
        return r;
    endfunction

endpackage

/* sv/ising_metropolis_site_update.sv */
// top level of the ising metropolis site update block: row memory, sequencer, output register
// depends on ising_pkg
//
// usage
//   input channel s_*: one transaction per site operation. s_mode selects a metropolis
//   step, a spin write or a spin read of site (s_site_x, s_site_y); coordinates wrap
//   modulo the lattice size. s_random_fraction is a uq0.32 uniform number for a step.
//   result channel m_*: exactly one transaction per input transaction, in order, with the
//   spin after the operation, the flip flag and the energy index (0 outside a step).
//   config channel cfg_*: cfg_index 0 writes the +4 flip probability, 1 the +8 one,
//   both uq0.32; always ready, write only while the block is idle.
// timing
//   the lattice is a memory of LATTICE_HEIGHT rows, one row per word, with two read
//   ports. a step needs three rows (site row, row above, row below): two are read in
//   the accept cycle and one in the next; the result is registered on m_* when the
//   item retires from the execute state, and a new transaction can be taken in that
//   same cycle while the row is written back (that write is forwarded to the next reads).
// reset
//   aresetn clears control and both probability registers, then a clearing pass writes
//   +1 into every row, one row per cycle, with s_ready low until the pass ends.
// stall
//   a result waits in the output register while m_ready is low; the block still accepts
//   and reads the next item, and holds it at its final cycle until the register frees.

module ising_metropolis_site_update (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic [5:0]            s_site_x,
    input  logic [5:0]            s_site_y,
    input  logic                  s_spin_in,
    input  logic [31:0]           s_random_fraction,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_spin_now,
    output logic                  m_flipped,
    output logic [2:0]            m_energy_index,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    // lattice row memory
    ising_pkg::row_t lattice_mem [ising_pkg::LATTICE_HEIGHT];

    ising_pkg::state_t state_reg, state_next;
    ising_pkg::line_t  clr_cnt_reg, clr_cnt_next;

    // probability registers
    ising_pkg::prob_t prob4_reg, prob8_reg;

    // captured item
    logic [1:0]        mode_reg;
    ising_pkg::col_t   x_reg;
    ising_pkg::line_t  y_reg;
    logic              spin_in_reg;
    ising_pkg::prob_t  frac_reg;

    // memory ports
    logic              rd0_en, rd1_en, wr_en;
    ising_pkg::line_t  rd0_addr, rd1_addr, wr_addr;
    ising_pkg::row_t   rd0_data_reg, rd1_data_reg, wr_row;

    // last write, for forwarding into reads issued in the same cycle
    logic              fwd_en_reg;
    ising_pkg::line_t  fwd_addr_reg;
    ising_pkg::row_t   fwd_row_reg;

    // rows held for the execute cycle
    ising_pkg::row_t   row_c_reg, row_u_reg;

    // output register
    logic              m_valid_reg;
    logic              spin_now_reg, flipped_reg;
    ising_pkg::eidx_t  eidx_reg;

    logic              accept, out_free, done;
    ising_pkg::col_t   in_x, x_right, x_left;
    ising_pkg::line_t  in_y, in_y_up, y_up, y_down;
    logic              s_bit, spin_new, flip;
    ising_pkg::eidx_t  agree, eidx;
    ising_pkg::row_t   row_new;

    assign cfg_ready = 1'b1;

    // wrapped input coordinates and the row above the incoming site
    always_comb begin
        in_x    = ising_pkg::col_t'(ising_pkg::wrap_coord(s_site_x, ising_pkg::LATTICE_WIDTH));
        in_y    = ising_pkg::line_t'(ising_pkg::wrap_coord(s_site_y, ising_pkg::LATTICE_HEIGHT));
        in_y_up = (in_y == '0) ? ising_pkg::line_t'(ising_pkg::LATTICE_HEIGHT - 1)
                               : in_y - 1'b1;
    end

    // neighbor coordinates of the item in flight, periodic boundaries
    always_comb begin
        x_right = (x_reg == ising_pkg::col_t'(ising_pkg::LATTICE_WIDTH - 1)) ? '0 : x_reg + 1'b1;
        x_left  = (x_reg == '0) ? ising_pkg::col_t'(ising_pkg::LATTICE_WIDTH - 1)
                                : x_reg - 1'b1;
        y_down  = (y_reg == ising_pkg::line_t'(ising_pkg::LATTICE_HEIGHT - 1)) ? '0
                                                                              : y_reg + 1'b1;
        y_up    = (y_reg == '0) ? ising_pkg::line_t'(ising_pkg::LATTICE_HEIGHT - 1)
                                : y_reg - 1'b1;
    end

    // site update, evaluated in the execute cycle; row below comes straight from port 1
    always_comb begin
        s_bit = row_c_reg[x_reg];
        // neighbors equal to the site spin: energy index is this count (d = 4*count - 8)
        agree = ising_pkg::eidx_t'(row_c_reg[x_right] ~^ s_bit)
              + ising_pkg::eidx_t'(row_c_reg[x_left]  ~^ s_bit)
              + ising_pkg::eidx_t'(row_u_reg[x_reg]   ~^ s_bit)
              + ising_pkg::eidx_t'(rd1_data_reg[x_reg] ~^ s_bit);
        flip     = 1'b0;
        eidx     = '0;
        spin_new = s_bit;
        case (mode_reg)
            ising_pkg::MODE_STEP: begin
                eidx = agree;
                if (agree == 3'd3) begin
                    flip = prob4_reg > frac_reg;
                end else if (agree == 3'd4) begin
                    flip = prob8_reg > frac_reg;
                end else begin
                    // energy change zero or below: always flip
                    flip = 1'b1;
                end
                spin_new = s_bit ^ flip;
            end
            ising_pkg::MODE_WRITE: begin
                spin_new = spin_in_reg;
            end
            default: begin
                // read, and the unused mode code
                spin_new = s_bit;
            end
        endcase
        row_new        = row_c_reg;
        row_new[x_reg] = spin_new;
    end

    // handshake and sequencer
    always_comb begin
        out_free   = !m_valid_reg || m_ready;
        done       = (state_reg == ising_pkg::ST_EXEC) && out_free;
        s_ready    = (state_reg == ising_pkg::ST_IDLE) || done;
        accept     = s_valid && s_ready;

        // reads: site row and row above at accept, row below in the fetch state that follows
        rd0_en     = accept;
        rd0_addr   = in_y;
        rd1_en     = accept || (state_reg == ising_pkg::ST_FETCH);
        rd1_addr   = accept ? in_y_up : y_down;

        // write back the site row when the item retires, or clear a row
        wr_en      = (state_reg == ising_pkg::ST_CLEAR) || done;
        wr_addr    = (state_reg == ising_pkg::ST_CLEAR) ? clr_cnt_reg : y_reg;
        wr_row     = (state_reg == ising_pkg::ST_CLEAR) ? '1 : row_new;

        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ising_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ising_pkg::line_t'(ising_pkg::LATTICE_HEIGHT - 1)) begin
                    state_next = ising_pkg::ST_IDLE;
                end
            end
            ising_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = ising_pkg::ST_FETCH;
                end
            end
            ising_pkg::ST_FETCH: begin
                state_next = ising_pkg::ST_EXEC;
            end
            ising_pkg::ST_EXEC: begin
                if (done) begin
                    state_next = accept ? ising_pkg::ST_FETCH : ising_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ising_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ising_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // lattice memory, one write and two registered reads per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            lattice_mem[wr_addr] <= wr_row;
        end
        if (rd0_en) begin
            rd0_data_reg <= lattice_mem[rd0_addr];
        end
        if (rd1_en) begin
            rd1_data_reg <= lattice_mem[rd1_addr];
        end
    end

    // forwarding of the write that shared a cycle with the reads
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_en_reg <= 1'b0;
        end else begin
            fwd_en_reg <= wr_en;
        end
        fwd_addr_reg <= wr_addr;
        fwd_row_reg  <= wr_row;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ising_pkg::ST_FETCH) begin
            row_c_reg <= (fwd_en_reg && (fwd_addr_reg == y_reg)) ? fwd_row_reg : rd0_data_reg;
            row_u_reg <= (fwd_en_reg && (fwd_addr_reg == y_up))  ? fwd_row_reg : rd1_data_reg;
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg    <= s_mode;
            x_reg       <= in_x;
            y_reg       <= in_y;
            spin_in_reg <= s_spin_in;
            frac_reg    <= s_random_fraction;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prob4_reg <= '0;
            prob8_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ising_pkg::CFG_PROB_PLUS4: prob4_reg <= cfg_data;
                ising_pkg::CFG_PROB_PLUS8: prob8_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            spin_now_reg <= spin_new;
            flipped_reg  <= flip && (mode_reg == ising_pkg::MODE_STEP);
            eidx_reg     <= eidx;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_spin_now     = spin_now_reg;
    assign m_flipped      = flipped_reg;
    assign m_energy_index = eidx_reg;

endmodule

/* sv/ising_checker.sv */
// port-level checker for ising_metropolis_site_update, attached by bind
// depends on the top level's port list

module ising_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_spin_now,
    input  logic        m_flipped,
    input  logic [2:0]  m_energy_index
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_spin_now) && $stable(m_flipped)
                                && $stable(m_energy_index))
        else $error("result transaction changed while stalled");

    // clearing pass keeps the input closed right after reset
    a_reset_closed: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block open or result pending right after reset");

    // the three row reads keep transactions out of consecutive cycles
    a_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !(s_valid && s_ready))
        else $error("input transactions accepted in consecutive cycles");

    // an unstalled result appears once its input transaction has passed the fetch and execute states
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 3))
        else $error("result without matching input transaction");

endmodule

bind ising_metropolis_site_update ising_checker u_ising_checker (.*);

/* sim/tb_top.sv */
// testbench for the ising metropolis site update block: directed and random site operations
// checked against a lattice predictor kept in the bench; depends on ising_pkg and the block rtl

module tb_top;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_SLACK   = 8;
    localparam int FINAL_WAIT    = 4000;
    localparam int HOLD_CYCLES   = 200;
    localparam int MAX_PRINTED   = 40;
    localparam int PHASE_ITEMS   = 210;
    localparam int LAT_W         = int'(ising_pkg::LATTICE_WIDTH);
    localparam int LAT_H         = int'(ising_pkg::LATTICE_HEIGHT);
    localparam int COORD_MAX     = (1 << ising_pkg::COORD_W) - 1;

    // mode code 3 has no name in the package; the block treats it as a read
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        ising_pkg::coord_t x;
        ising_pkg::coord_t y;
        logic              spin;
        ising_pkg::prob_t  frac;
    } site_op_t;

    typedef struct packed {
        logic             spin_now;
        logic             flipped;
        ising_pkg::eidx_t energy_index;
    } site_result_t;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_style_t;
    typedef enum {TX_STREAM, TX_BURSTY, TX_SPARSE} tx_style_t;

    // clock, reset and block ports; every input starts at a known value
    logic        aclk              = 1'b0;
    logic        aresetn           = 1'b0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode            = ising_pkg::MODE_READ;
    logic [5:0]  s_site_x          = '0;
    logic [5:0]  s_site_y          = '0;
    logic        s_spin_in         = 1'b0;
    logic [31:0] s_random_fraction = '0;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic        m_spin_now;
    logic        m_flipped;
    logic [2:0]  m_energy_index;
    logic        cfg_valid         = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index         = ising_pkg::CFG_PROB_PLUS4;
    logic [31:0] cfg_data          = '0;

    // predictor state: lattice copy and the two flip probabilities
    bit               spin_grid [LAT_H][LAT_W];
    ising_pkg::prob_t prob_plus4 = '0;
    ising_pkg::prob_t prob_plus8 = '0;

    // results predicted at input acceptance, oldest first
    site_result_t pending_results[$];

    int error_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int step_count      = 0;
    int flip_count      = 0;
    int write_count     = 0;
    int read_count      = 0;
    int energy_seen [5] = '{default: 0};
    int cycle_count     = 0;

    // sender and receiver pacing
    rx_style_t rx_style      = RX_ALWAYS;
    tx_style_t tx_style      = TX_STREAM;
    int        burst_left    = 0;
    int        hold_requests = 0;
    int        holds_served  = 0;
    int        hold_left     = 0;
    int        rx_phase      = 0;

    ising_metropolis_site_update dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_site_x          (s_site_x),
        .s_site_y          (s_site_y),
        .s_spin_in         (s_spin_in),
        .s_random_fraction (s_random_fraction),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_spin_now        (m_spin_now),
        .m_flipped         (m_flipped),
        .m_energy_index    (m_energy_index),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("error at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // +1 or -1 for the stored spin
    function automatic int spin_at(input int x, input int y);
        return spin_grid[y][x] ? 1 : -1;
    endfunction

    // coordinate moved by d with wraparound over n sites
    function automatic ising_pkg::coord_t shift_coord(input ising_pkg::coord_t c, input int d,
                                                      input int n);
        return ising_pkg::coord_t'((int'(c) + d + n) % n);
    endfunction

    // applies one site operation to the lattice copy and returns its result
    function automatic site_result_t apply_site_op(input site_op_t op);
        int           xi;
        int           yi;
        int           xl;
        int           xr;
        int           yu;
        int           yd;
        int           nsum;
        int           delta;
        logic         accept;
        site_result_t res;
        xi  = int'(op.x) % LAT_W;
        yi  = int'(op.y) % LAT_H;
        res = '0;
        case (op.mode)
            ising_pkg::MODE_STEP: begin
                xr    = (xi == LAT_W - 1) ? 0 : xi + 1;
                xl    = (xi == 0) ? LAT_W - 1 : xi - 1;
                yd    = (yi == LAT_H - 1) ? 0 : yi + 1;
                yu    = (yi == 0) ? LAT_H - 1 : yi - 1;
                nsum  = spin_at(xr, yi) + spin_at(xl, yi) + spin_at(xi, yd) + spin_at(xi, yu);
                delta = 2 * spin_at(xi, yi) * nsum;
                // energy gain of zero or less always flips; +4 and +8 compare probabilities
                if (delta <= 0) begin
                    accept = 1'b1;
                end else if (delta == 4) begin
                    accept = prob_plus4 > op.frac;
                end else begin
                    accept = prob_plus8 > op.frac;
                end
                if (accept) begin
                    spin_grid[yi][xi] = ~spin_grid[yi][xi];
                    flip_count++;
                end
                res.flipped      = accept;
                res.energy_index = ising_pkg::eidx_t'((delta + 8) / 4);
                energy_seen[(delta + 8) / 4]++;
                step_count++;
            end
            ising_pkg::MODE_WRITE: begin
                spin_grid[yi][xi] = op.spin;
                write_count++;
            end
            default: begin
                read_count++;
            end
        endcase
        res.spin_now = spin_grid[yi][xi];
        return res;
    endfunction

    // receiver: own stall pattern, with long hold-offs on request
    always @(posedge aclk) begin
        rx_phase++;
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_style)
                RX_ALWAYS:  m_ready <= 1'b1;
                RX_RANDOM:  m_ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: m_ready <= ((rx_phase % 7) < 3);
                default:    m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker: each result transaction against the oldest prediction
    always @(posedge aclk) begin
        site_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing predicted",
                                          results_checked));
            end else begin
                want = pending_results.pop_front();
                if (m_spin_now !== want.spin_now) begin
                    report_mismatch($sformatf("result %0d spin_now %b, predicted %b",
                                              results_checked, m_spin_now, want.spin_now));
                end
                if (m_flipped !== want.flipped) begin
                    report_mismatch($sformatf("result %0d flipped %b, predicted %b",
                                              results_checked, m_flipped, want.flipped));
                end
                if (m_energy_index !== want.energy_index) begin
                    report_mismatch($sformatf("result %0d energy_index %0d, predicted %0d",
                                              results_checked, m_energy_index,
                                              want.energy_index));
                end
            end
        end
    end

    // sender gap after a transaction, by the current sender style
    task automatic pace_sender();
        int gap;
        case (tx_style)
            TX_STREAM: gap = 0;
            TX_SPARSE: gap = $urandom_range(0, 5);
            default: begin
                burst_left--;
                if (burst_left > 0) begin
                    gap = 0;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap        = $urandom_range(1, 9);
                end
            end
        endcase
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // one input transaction; valid stays up into the next call when there is no gap
    task automatic send_site_op(input site_op_t op);
        s_valid           <= 1'b1;
        s_mode            <= op.mode;
        s_site_x          <= op.x;
        s_site_y          <= op.y;
        s_spin_in         <= op.spin;
        s_random_fraction <= op.frac;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(apply_site_op(op));
        items_sent++;
        pace_sender();
    endtask

    // sender stops and waits until every predicted result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    // both probability registers back to back, only while the block is idle
    task automatic set_flip_probs(input ising_pkg::prob_t p4, input ising_pkg::prob_t p8);
        cfg_valid <= 1'b1;
        cfg_index <= ising_pkg::CFG_PROB_PLUS4;
        cfg_data  <= p4;
        do @(posedge aclk); while (!cfg_ready);
        prob_plus4 = p4;
        cfg_index <= ising_pkg::CFG_PROB_PLUS8;
        cfg_data  <= p8;
        do @(posedge aclk); while (!cfg_ready);
        prob_plus8 = p8;
        cfg_valid <= 1'b0;
    endtask

    // edges of the lattice come up often so that wraparound is exercised
    function automatic ising_pkg::coord_t pick_coord();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return ising_pkg::coord_t'(LAT_W - 1);
            default: return ising_pkg::coord_t'($urandom_range(0, COORD_MAX));
        endcase
    endfunction

    // fraction: extremes, values around either threshold, or uniform
    function automatic ising_pkg::prob_t pick_fraction();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return prob_plus4 + ising_pkg::prob_t'($urandom_range(0, 2))
                            - ising_pkg::prob_t'(1);
            4, 5:    return prob_plus8 + ising_pkg::prob_t'($urandom_range(0, 2))
                            - ising_pkg::prob_t'(1);
            default: return ising_pkg::prob_t'($urandom());
        endcase
    endfunction

    function automatic site_op_t make_random_op(input ising_pkg::coord_t cx,
                                                input ising_pkg::coord_t cy);
        site_op_t op;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            op.mode = ising_pkg::MODE_STEP;
        end else if (pick < 84) begin
            op.mode = ising_pkg::MODE_WRITE;
        end else if (pick < 95) begin
            op.mode = ising_pkg::MODE_READ;
        end else begin
            op.mode = MODE_UNUSED;
        end
        // half the sites anywhere, half in a small window so neighbours interact
        if ($urandom_range(0, 1) == 1) begin
            op.x = ising_pkg::coord_t'($urandom_range(0, COORD_MAX));
            op.y = ising_pkg::coord_t'($urandom_range(0, COORD_MAX));
        end else begin
            op.x = shift_coord(cx, int'($urandom_range(0, 4)) - 2, LAT_W);
            op.y = shift_coord(cy, int'($urandom_range(0, 4)) - 2, LAT_H);
        end
        op.spin = 1'($urandom_range(0, 1));
        op.frac = pick_fraction();
        return op;
    endfunction

    // well-formed sequence: load a site and its four neighbours, step it, read it back
    task automatic send_neighbourhood(input ising_pkg::coord_t x, input ising_pkg::coord_t y);
        site_op_t op;
        op.mode = ising_pkg::MODE_WRITE;
        op.frac = ising_pkg::prob_t'($urandom());
        for (int k = 0; k < 5; k++) begin
            op.x = x;
            op.y = y;
            case (k)
                1:       op.x = shift_coord(x, 1, LAT_W);
                2:       op.x = shift_coord(x, -1, LAT_W);
                3:       op.y = shift_coord(y, 1, LAT_H);
                4:       op.y = shift_coord(y, -1, LAT_H);
                default: ;
            endcase
            op.spin = 1'($urandom_range(0, 1));
            send_site_op(op);
        end
        op.x    = x;
        op.y    = y;
        op.mode = ising_pkg::MODE_STEP;
        repeat ($urandom_range(1, 3)) begin
            op.spin = 1'($urandom_range(0, 1));
            op.frac = pick_fraction();
            send_site_op(op);
        end
        op.mode = ising_pkg::MODE_READ;
        send_site_op(op);
    endtask

    function automatic site_op_t site_op(input logic [1:0] mode, input int x, input int y,
                                         input logic spin, input ising_pkg::prob_t frac);
        site_op_t op;
        op.mode = mode;
        op.x    = ising_pkg::coord_t'(x);
        op.y    = ising_pkg::coord_t'(y);
        op.spin = spin;
        op.frac = frac;
        return op;
    endfunction

    // reset lattice, every energy class around the wrapping corner site, threshold edges
    task automatic test_directed_cases();
        rx_style = RX_ALWAYS;
        tx_style = TX_STREAM;
        send_site_op(site_op(ising_pkg::MODE_READ, 0, 0, 1'b0, '0));
        send_site_op(site_op(MODE_UNUSED, 63, 63, 1'b0, '1));
        // all +1 lattice gives +8; zero probability never flips
        send_site_op(site_op(ising_pkg::MODE_STEP, 0, 0, 1'b1, '0));
        wait_drained();
        set_flip_probs('1, 32'h8000_0000);
        send_site_op(site_op(ising_pkg::MODE_STEP, 63, 63, 1'b0, 32'h7fff_ffff));
        // fraction equal to the probability is not accepted
        send_site_op(site_op(ising_pkg::MODE_STEP, 0, 0, 1'b0, 32'h8000_0000));
        send_site_op(site_op(ising_pkg::MODE_WRITE, 1, 0, 1'b0, '0));
        send_site_op(site_op(ising_pkg::MODE_STEP, 0, 0, 1'b0, 32'hffff_fffe));
        send_site_op(site_op(ising_pkg::MODE_STEP, 0, 0, 1'b0, '1));
        send_site_op(site_op(ising_pkg::MODE_WRITE, 63, 0, 1'b0, '0));
        send_site_op(site_op(ising_pkg::MODE_STEP, 0, 0, 1'b1, '1));
        send_site_op(site_op(ising_pkg::MODE_STEP, 0, 0, 1'b1, '1));
        send_site_op(site_op(ising_pkg::MODE_WRITE, 0, 63, 1'b0, '1));
        send_site_op(site_op(ising_pkg::MODE_WRITE, 0, 1, 1'b0, '1));
        send_site_op(site_op(ising_pkg::MODE_STEP, 0, 0, 1'b0, '1));
        send_site_op(site_op(ising_pkg::MODE_STEP, 0, 0, 1'b0, '1));
        wait_drained();
        set_flip_probs('0, '1);
        send_site_op(site_op(ising_pkg::MODE_WRITE, 1, 0, 1'b1, '0));
        send_site_op(site_op(ising_pkg::MODE_STEP, 0, 0, 1'b1, '0));
        send_site_op(site_op(ising_pkg::MODE_WRITE, 63, 63, 1'b1, '1));
        send_site_op(site_op(ising_pkg::MODE_READ, 63, 63, 1'b0, '0));
        wait_drained();
    endtask

    // one probability setting with random pacing on both sides
    task automatic run_random_phase(input ising_pkg::prob_t p4, input ising_pkg::prob_t p8,
                                    input int n_items);
        int                stop_at;
        ising_pkg::coord_t cx;
        ising_pkg::coord_t cy;
        wait_drained();
        set_flip_probs(p4, p8);
        rx_style   = rx_style_t'($urandom_range(0, 3));
        tx_style   = tx_style_t'($urandom_range(0, 2));
        burst_left = $urandom_range(1, 16);
        stop_at    = items_sent + n_items;
        cx         = pick_coord();
        cy         = pick_coord();
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) < 4) begin
                send_neighbourhood(pick_coord(), pick_coord());
            end else begin
                if ($urandom_range(0, 7) == 0) begin
                    cx = pick_coord();
                    cy = pick_coord();
                end
                send_site_op(make_random_op(cx, cy));
            end
        end
    endtask

    task automatic test_random_phases();
        run_random_phase('0, '0, PHASE_ITEMS);
        run_random_phase('1, '1, PHASE_ITEMS);
        run_random_phase(32'h8000_0000, 32'h4000_0000, PHASE_ITEMS);
        run_random_phase(ising_pkg::prob_t'($urandom()), ising_pkg::prob_t'($urandom()),
                         PHASE_ITEMS);
        run_random_phase('1, '0, PHASE_ITEMS);
        run_random_phase(ising_pkg::prob_t'($urandom()), 32'h0000_0001, PHASE_ITEMS);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering transactions
    task automatic test_output_hold();
        wait_drained();
        rx_style = RX_ALWAYS;
        tx_style = TX_STREAM;
        hold_requests++;
        repeat (80) send_site_op(make_random_op(pick_coord(), pick_coord()));
        wait_drained();
    endtask

    // sender stops mid-stream until everything is back, then resumes with no new setting
    task automatic test_sender_pause();
        rx_style   = RX_RANDOM;
        tx_style   = TX_BURSTY;
        burst_left = 4;
        repeat (20) send_site_op(make_random_op(pick_coord(), pick_coord()));
        wait_drained();
        repeat (20) send_site_op(make_random_op(pick_coord(), pick_coord()));
        wait_drained();
    endtask

    initial begin
        foreach (spin_grid[r, c]) spin_grid[r][c] = 1'b1;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_random_phases();
        test_output_hold();
        test_sender_pause();

        // bounded wait for stragglers; anything left is a missing result
        for (int i = 0; i < FINAL_WAIT && pending_results.size() != 0; i++) @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      pending_results.size()));
        end

        $display("covered %0d site transactions: %0d steps, %0d flips, %0d writes, %0d reads",
                 items_sent, step_count, flip_count, write_count, read_count);
        $display("steps per energy index 0..4: %0d %0d %0d %0d %0d, %0d results checked",
                 energy_seen[0], energy_seen[1], energy_seen[2], energy_seen[3],
                 energy_seen[4], results_checked);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
